[src/interval_booking_overlap_limit_unit_assert.svh]
// Assertion helpers for the booking unit's controller.
`ifndef INTERVAL_BOOKING_OVERLAP_LIMIT_UNIT_ASSERT_SVH
`define INTERVAL_BOOKING_OVERLAP_LIMIT_UNIT_ASSERT_SVH

// Same-cycle implication.
`define IBOL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ibol: property violated");

// Next-cycle implication.
`define IBOL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ibol: property violated");

`endif

[src/ibol_pkg.sv]
package ibol_pkg;

  localparam int unsigned TIME_W  = 30;
  localparam int unsigned DELTA_W = 9;
  localparam int unsigned MAX_W   = 8;
  // running sums stay within 0..256; SUM_W = 11 leaves spare bits for the signed compare
  localparam int unsigned SUM_W   = 11;

  localparam logic [MAX_W-1:0]   MAX_OVERLAP_RST = 8'd2;
  localparam logic [DELTA_W-1:0] DELTA_ONE       = 9'd1;
  localparam logic [DELTA_W-1:0] DELTA_MINUS_ONE = '1;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } ibol_in_t;

  typedef struct packed {
    logic accepted;
    logic table_full;
  } ibol_out_t;

  // one boundary: time and two's complement net change
  typedef struct packed {
    logic [TIME_W-1:0]  tstamp;
    logic [DELTA_W-1:0] delta;
  } ibol_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DECIDE,
    ST_INS_S,
    ST_INS_E,
    ST_REPLY
  } ibol_state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ROTATE,
    OP_UPDATE
  } ibol_op_e;

  typedef struct packed {
    ibol_op_e           op;
    logic [TIME_W-1:0]  key;
    logic [DELTA_W-1:0] delta;
    logic               present;
    logic               zero;
  } ibol_cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic head_valid;
  } ibol_sweep_ctrl_t;

  typedef struct packed {
    logic ok;
    logic full;
    logic s_present;
    logic s_zero;
    logic e_present;
    logic e_zero;
  } ibol_sweep_t;

endpackage

[src/ibol_cell.sv]
module ibol_cell (
  input  logic                     clk_i,
  input  ibol_pkg::ibol_cell_ctrl_t ctrl_i,
  input  logic                     valid_i,
  input  logic                     left_lt_i,
  input  ibol_pkg::ibol_entry_t    left_i,
  input  ibol_pkg::ibol_entry_t    right_i,
  output ibol_pkg::ibol_entry_t    entry_o,
  output logic                     lt_o
);
  import ibol_pkg::*;

  ibol_entry_t entry_q, entry_d;
  logic        eq;

  assign lt_o = valid_i & (entry_q.tstamp < ctrl_i.key);
  assign eq   = valid_i & (entry_q.tstamp == ctrl_i.key);

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      OP_HOLD: begin
        entry_d = entry_q;
      end
      OP_ROTATE: begin
        entry_d = right_i;
      end
      OP_UPDATE: begin
        if (ctrl_i.present) begin
          if (ctrl_i.zero) begin
            // matched entry drops out, tail closes up from the right
            if (!lt_o) begin
              entry_d = right_i;
            end
          end else if (eq) begin
            entry_d.delta = entry_q.delta + ctrl_i.delta;
          end
        end else if (!lt_o) begin
          // first cell at or past the key takes it, the rest move right
          if (left_lt_i) begin
            entry_d.tstamp = ctrl_i.key;
            entry_d.delta  = ctrl_i.delta;
          end else begin
            entry_d = left_i;
          end
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[src/ibol_sweep.sv]
module ibol_sweep #(
  parameter  int unsigned TABLE_DEPTH = 256,
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ibol_pkg::ibol_sweep_ctrl_t ctrl_i,
  input  ibol_pkg::ibol_entry_t      head_i,
  input  ibol_pkg::ibol_in_t         req_i,
  input  logic [ibol_pkg::MAX_W-1:0] max_i,
  input  logic [CNT_W-1:0]           count_i,
  output ibol_pkg::ibol_sweep_t      status_o
);
  import ibol_pkg::*;

  logic signed [SUM_W-1:0] prefix_q, prefix_d, below_q, below_d;
  logic signed [SUM_W-1:0] step_sum, trial, limit;
  logic                    ok_q, ok_d;
  logic                    sp_q, sp_d, sz_q, sz_d, ep_q, ep_d, ez_q, ez_d;
  logic                    in_span, span, gap_over, take;
  logic [1:0]              need;
  logic [CNT_W:0]          demand;

  assign take     = ctrl_i.step & ctrl_i.head_valid;
  assign span     = req_i.start_time < req_i.end_time;
  assign in_span  = (head_i.tstamp >= req_i.start_time) & (head_i.tstamp < req_i.end_time);
  assign limit    = $signed({{(SUM_W - MAX_W){1'b0}}, max_i});
  assign step_sum = prefix_q + SUM_W'($signed(head_i.delta));
  assign trial    = step_sum + $signed({{(SUM_W - 1){1'b0}}, in_span});

  always_comb begin
    prefix_d = prefix_q;
    below_d  = below_q;
    ok_d     = ok_q;
    sp_d     = sp_q;
    sz_d     = sz_q;
    ep_d     = ep_q;
    ez_d     = ez_q;
    if (ctrl_i.clear) begin
      prefix_d = '0;
      below_d  = '0;
      ok_d     = 1'b1;
      sp_d     = 1'b0;
      sz_d     = 1'b0;
      ep_d     = 1'b0;
      ez_d     = 1'b0;
    end else if (take) begin
      prefix_d = step_sum;
      if (trial > limit) begin
        ok_d = 1'b0;
      end
      // level just before the start time, for a start that is new
      if (head_i.tstamp < req_i.start_time) begin
        below_d = step_sum;
      end
      if (head_i.tstamp == req_i.start_time) begin
        sp_d = 1'b1;
        sz_d = head_i.delta == DELTA_MINUS_ONE;
      end
      if (head_i.tstamp == req_i.end_time) begin
        ep_d = 1'b1;
        ez_d = head_i.delta == DELTA_ONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b1;
      sp_q <= 1'b0;
      sz_q <= 1'b0;
      ep_q <= 1'b0;
      ez_q <= 1'b0;
    end else begin
      ok_q <= ok_d;
      sp_q <= sp_d;
      sz_q <= sz_d;
      ep_q <= ep_d;
      ez_q <= ez_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prefix_q <= prefix_d;
    below_q  <= below_d;
  end

  assign gap_over = span & !sp_q & ((below_q + SUM_W'(1)) > limit);
  assign need     = {1'b0, !sp_q} + {1'b0, !ep_q};
  assign demand   = {1'b0, count_i} + (CNT_W + 1)'(need);

  assign status_o.ok        = ok_q & !gap_over;
  assign status_o.full      = demand > (CNT_W + 1)'(TABLE_DEPTH);
  assign status_o.s_present = sp_q;
  assign status_o.s_zero    = sz_q;
  assign status_o.e_present = ep_q;
  assign status_o.e_zero    = ez_q;

endmodule

[src/ibol_ctrl.sv]
`include "interval_booking_overlap_limit_unit_assert.svh"

module ibol_ctrl #(
  parameter  int unsigned TABLE_DEPTH = 256,
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ibol_pkg::ibol_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ibol_pkg::ibol_out_t        out_data_o,
  input  ibol_pkg::ibol_sweep_t      status_i,
  output ibol_pkg::ibol_in_t         req_o,
  output logic [CNT_W-1:0]           count_o,
  output ibol_pkg::ibol_cell_ctrl_t  cell_ctrl_o,
  output ibol_pkg::ibol_sweep_ctrl_t sweep_ctrl_o
);
  import ibol_pkg::*;

  ibol_state_e      state_q, state_d;
  logic [IDX_W-1:0] rot_q, rot_d;
  logic [CNT_W-1:0] count_q, count_d;
  ibol_in_t         req_q, req_d;
  logic             span_q, span_d;
  ibol_out_t        verdict_q, verdict_d, dec;
  logic             out_valid_q, out_valid_d;
  ibol_out_t        out_data_q, out_data_d;
  logic             accept_in, out_free, last_rot, commit;

  assign in_stall_o = state_q != ST_IDLE;
  assign accept_in  = in_valid_i & !in_stall_o;
  assign out_free   = !out_valid_q | !out_stall_i;
  assign last_rot   = rot_q == IDX_W'(TABLE_DEPTH - 1);

  assign dec.accepted   = status_i.ok & !(span_q & status_i.full);
  assign dec.table_full = span_q & status_i.full;
  assign commit         = span_q & dec.accepted;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_in) begin
          if (in_data_i.start_time > in_data_i.end_time) begin
            state_d = ST_REPLY;
          end else begin
            state_d = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (last_rot) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = commit ? ST_INS_S : ST_REPLY;
      end
      ST_INS_S: begin
        state_d = ST_INS_E;
      end
      ST_INS_E: begin
        state_d = ST_REPLY;
      end
      ST_REPLY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs to the ring and the sweep unit
  always_comb begin
    cell_ctrl_o.op      = OP_HOLD;
    cell_ctrl_o.key     = '0;
    cell_ctrl_o.delta   = '0;
    cell_ctrl_o.present = 1'b0;
    cell_ctrl_o.zero    = 1'b0;
    sweep_ctrl_o.clear      = 1'b0;
    sweep_ctrl_o.step       = 1'b0;
    sweep_ctrl_o.head_valid = CNT_W'(rot_q) < count_q;
    case (state_q)
      ST_IDLE: begin
        sweep_ctrl_o.clear = accept_in;
      end
      ST_SWEEP: begin
        cell_ctrl_o.op    = OP_ROTATE;
        sweep_ctrl_o.step = 1'b1;
      end
      ST_INS_S: begin
        cell_ctrl_o.op      = OP_UPDATE;
        cell_ctrl_o.key     = req_q.start_time;
        cell_ctrl_o.delta   = DELTA_ONE;
        cell_ctrl_o.present = status_i.s_present;
        cell_ctrl_o.zero    = status_i.s_zero;
      end
      ST_INS_E: begin
        cell_ctrl_o.op      = OP_UPDATE;
        cell_ctrl_o.key     = req_q.end_time;
        cell_ctrl_o.delta   = DELTA_MINUS_ONE;
        cell_ctrl_o.present = status_i.e_present;
        cell_ctrl_o.zero    = status_i.e_zero;
      end
      default: begin
        cell_ctrl_o.op = OP_HOLD;
      end
    endcase
  end

  always_comb begin
    rot_d       = rot_q;
    count_d     = count_q;
    req_d       = req_q;
    span_d      = span_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (accept_in) begin
      rot_d     = '0;
      req_d     = in_data_i;
      span_d    = in_data_i.start_time < in_data_i.end_time;
      verdict_d = '0;
    end
    if (state_q == ST_SWEEP) begin
      rot_d = last_rot ? '0 : rot_q + IDX_W'(1);
    end
    if (state_q == ST_DECIDE) begin
      verdict_d = dec;
    end
    if (state_q == ST_INS_S) begin
      if (!status_i.s_present) begin
        count_d = count_q + CNT_W'(1);
      end else if (status_i.s_zero) begin
        count_d = count_q - CNT_W'(1);
      end
    end
    if (state_q == ST_INS_E) begin
      if (!status_i.e_present) begin
        count_d = count_q + CNT_W'(1);
      end else if (status_i.e_zero) begin
        count_d = count_q - CNT_W'(1);
      end
    end
    if (state_q == ST_REPLY && out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = verdict_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rot_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rot_q       <= rot_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    span_q     <= span_d;
    verdict_q  <= verdict_d;
    out_data_q <= out_data_d;
  end

  assign req_o       = req_q;
  assign count_o     = count_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `IBOL_ASSERT_IMP(a_count_in_range, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
  `IBOL_ASSERT_IMP(a_commit_after_decide, clk_i, rst_ni, state_q == ST_INS_S, $past(state_q) == ST_DECIDE)
  `IBOL_ASSERT_IMP(a_reply_exclusive, clk_i, rst_ni, out_valid_q, !(out_data_q.accepted && out_data_q.table_full))
  `IBOL_ASSERT_NXT(a_count_only_on_commit, clk_i, rst_ni, state_q != ST_INS_S && state_q != ST_INS_E, $stable(count_q))

endmodule

[src/interval_booking_overlap_limit_unit.sv]
// A booking is taken only in idle and the next is held off until its reply beat is issued; a kept
// booking is swept, decided and then has its start and end inserted, a rejected or empty one
// is swept and decided only, and an inverted interval goes straight to the reply.
// Each swept booking turns the whole boundary ring once past the sweep accumulator, one cell
// per cycle. A stalled result beat holds off the next reply.
// Reset: empty table, max_overlap = 2, no clearing pass; cell contents are not reset.
module interval_booking_overlap_limit_unit #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ibol_pkg::ibol_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ibol_pkg::ibol_out_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ibol_pkg::MAX_W-1:0] cfg_data_i
);
  import ibol_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [MAX_W-1:0]       max_overlap_q;
  logic [CNT_W-1:0]       count;
  ibol_in_t               req;
  ibol_cell_ctrl_t        cell_ctrl;
  ibol_sweep_ctrl_t       sweep_ctrl;
  ibol_sweep_t            status;
  ibol_entry_t            entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt;
  logic [TABLE_DEPTH-1:0] cell_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_overlap_q <= MAX_OVERLAP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_overlap_q <= cfg_data_i;
    end
  end

  ibol_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .status_i    (status),
    .req_o       (req),
    .count_o     (count),
    .cell_ctrl_o (cell_ctrl),
    .sweep_ctrl_o(sweep_ctrl)
  );

  ibol_sweep #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sweep_ctrl),
    .head_i  (entry[0]),
    .req_i   (req),
    .max_i   (max_overlap_q),
    .count_i (count),
    .status_o(status)
  );

  // ring of boundary cells, cell 0 holds the earliest entry when aligned
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int unsigned LEFT  = (i == 0) ? TABLE_DEPTH - 1 : i - 1;
    localparam int unsigned RIGHT = (i + 1) % TABLE_DEPTH;

    assign cell_valid[i] = CNT_W'(i) < count;

    ibol_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .valid_i  (cell_valid[i]),
      .left_lt_i((i == 0) ? 1'b1 : lt[LEFT]),
      .left_i   (entry[LEFT]),
      .right_i  (entry[RIGHT]),
      .entry_o  (entry[i]),
      .lt_o     (lt[i])
    );
  end

endmodule

[tb/testbench.sv]
module testbench;
  import ibol_pkg::*;

  localparam int unsigned DEPTH = 256;
  localparam logic [TIME_W-1:0] TMAX = '1;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned WATCHDOG_LIMIT = 6000;

  typedef struct {
    logic [TIME_W-1:0] stamp;
    int                change;
  } mark_t;

  class booking_ledger;
    mark_t       marks[$];     // kept boundaries, sorted by time, no zero change
    ibol_out_t   verdicts[$];
    int unsigned limit;
    int unsigned errors;

    function new();
      limit  = 32'(MAX_OVERLAP_RST);
      errors = 0;
    endfunction

    function void set_limit(logic [MAX_W-1:0] value);
      limit = 32'(value);
    endfunction

    function bit has_time(logic [TIME_W-1:0] t);
      foreach (marks[i]) if (marks[i].stamp == t) return 1;
      return 0;
    endfunction

    function bit level_fits(mark_t list[$]);
      int sum;
      sum = 0;
      foreach (list[i]) begin
        sum += list[i].change;
        if (sum > int'(limit)) return 0;
      end
      return 1;
    endfunction

    function void add_change(ref mark_t list[$], input logic [TIME_W-1:0] t, input int d);
      int i;
      i = 0;
      while (i < list.size() && list[i].stamp < t) i++;
      if (i < list.size() && list[i].stamp == t) begin
        list[i].change += d;
      end else begin
        list.insert(i, '{stamp: t, change: d});
      end
    endfunction

    function void note_booking(ibol_in_t b);
      mark_t     trial[$];
      mark_t     kept[$];
      ibol_out_t v;
      int        need;
      v = '0;
      if (b.start_time == b.end_time) begin
        v.accepted = level_fits(marks);
      end else if (b.start_time < b.end_time) begin
        need = int'(!has_time(b.start_time)) + int'(!has_time(b.end_time));
        if (marks.size() + need > DEPTH) begin
          v.table_full = 1'b1;
        end else begin
          trial = marks;
          add_change(trial, b.start_time, 1);
          add_change(trial, b.end_time, -1);
          foreach (trial[i]) if (trial[i].change != 0) kept.push_back(trial[i]);
          if (level_fits(kept)) begin
            marks      = kept;
            v.accepted = 1'b1;
          end
        end
      end
      verdicts.push_back(v);
    endfunction

    function void check_result(ibol_out_t got);
      ibol_out_t want;
      if (verdicts.size() == 0) begin
        $error("result beat with no booking outstanding: accepted=%0b table_full=%0b",
               got.accepted, got.table_full);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
        errors++;
      end
      if (got.table_full !== want.table_full) begin
        $error("table_full: expected %0b, got %0b", want.table_full, got.table_full);
        errors++;
      end
    endfunction

    function logic [TIME_W-1:0] any_boundary();
      if (marks.size() == 0) return '0;
      return marks[$urandom_range(marks.size() - 1)].stamp;
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  ibol_in_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  ibol_out_t          out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [MAX_W-1:0]   cfg_data_i = '0;

  booking_ledger ledger = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  interval_booking_overlap_limit_unit #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) ledger.set_limit(cfg_data_i);
      if (out_valid_o && !out_stall_i) ledger.check_result(out_data_o);
      if (in_valid_i && !in_stall_o) ledger.note_booking(in_data_i);
    end
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 36);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic offer(input ibol_in_t b);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic quiet_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (ledger.verdicts.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [MAX_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic ibol_in_t span_booking(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e);
    ibol_in_t b;
    b.start_time = s;
    b.end_time   = e;
    return b;
  endfunction

  function automatic logic [TIME_W-1:0] draw_time(int unsigned span, int unsigned reuse);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return TMAX;
    if (r < 5) return '0;
    if ($urandom_range(99) < reuse && ledger.marks.size() != 0) return ledger.any_boundary();
    if (span == 32'(TMAX)) return TIME_W'($urandom());
    return TIME_W'($urandom_range(span));
  endfunction

  function automatic ibol_in_t draw_booking(int unsigned span, int unsigned reuse);
    logic [TIME_W-1:0] a, c;
    int unsigned       kind;
    a    = draw_time(span, reuse);
    c    = draw_time(span, reuse);
    kind = $urandom_range(99);
    if (kind < 10) return span_booking(a, a);
    if (a == c) c = (a == TMAX) ? a - TIME_W'(1) : a + TIME_W'(1);
    // mostly well-formed; some inverted
    if (kind < 18) return (a > c) ? span_booking(a, c) : span_booking(c, a);
    return (a < c) ? span_booking(a, c) : span_booking(c, a);
  endfunction

  task automatic run_phase(input logic [MAX_W-1:0] lim, input int unsigned n,
                           input int unsigned span, input int unsigned reuse,
                           input bit no_idle, input bit hold, input bit pause);
    drain();
    write_limit(lim);
    @(posedge clk_i);
    calm     = no_idle;
    hold_req = hold;
    for (int i = 0; i < n; i++) begin
      if (pause && i == n / 2) begin
        quiet_input();
        drain();
      end
      offer(draw_booking(span, reuse));
    end
    quiet_input();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset limit of 2 first
    offer(span_booking(0, 0));
    offer(span_booking(1, 0));
    offer(span_booking(TMAX, 0));
    offer(span_booking(100, 200));
    offer(span_booking(200, 300));     // shared boundary cancels out
    offer(span_booking(150, 250));
    offer(span_booking(160, 170));     // third overlap
    offer(span_booking(100, 100));
    offer(span_booking(0, TMAX));
    offer(span_booking(300, TMAX));
    offer(span_booking(TMAX - TIME_W'(1), TMAX));
    offer(span_booking(0, 1));
    quiet_input();
    drain();
    write_limit(0);                    // below the stored level
    offer(span_booking(5, 5));
    offer(span_booking(0, 0));
    quiet_input();
    drain();
    write_limit(8'hFF);
    offer(span_booking(0, TMAX));
    offer(span_booking(30'h1555_5555, 30'h2AAA_AAAA));
    offer(span_booking(30'h2AAA_AAAA, 30'h1555_5555));
    offer(span_booking(TMAX, TMAX));
    quiet_input();

    run_phase(8'd2,   180, 63,         30, 1'b0, 1'b0, 1'b1);
    run_phase(8'd0,   30,  63,         30, 1'b0, 1'b0, 1'b0);
    run_phase(8'd1,   50,  255,        30, 1'b0, 1'b0, 1'b0);
    run_phase(8'd5,   120, 4095,       40, 1'b1, 1'b0, 1'b0);
    run_phase(8'hFF,  280, 32'(TMAX),  15, 1'b0, 1'b1, 1'b0);
    run_phase(8'd3,   40,  32'(TMAX),  50, 1'b0, 1'b0, 1'b0);
    run_phase(8'd128, 200, 32'(TMAX),  60, 1'b0, 1'b0, 1'b0);

    drain();
    repeat (DEPTH + 8) @(negedge clk_i);
    if (ledger.verdicts.size() != 0) begin
      $error("%0d bookings never answered", ledger.verdicts.size());
      ledger.errors++;
    end
    if (ledger.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
